/* rtl/dace_pkg.sv */
// Shared types, opcodes and helpers for the digraph adjacency contraction engine.
// No dependencies; used by dace_ctrl, dace_datapath and the top level.
package dace_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int ROWS         = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
   localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int VERT_W       = 6;
   localparam int OP_W         = 4;
   localparam int COUNT_W      = 7;
   localparam int ROW_BITS     = 64;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [VERT_W-1:0]   vertex_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [ROW_BITS-1:0] row_type;
   typedef logic [ROW_W-1:0]    addr_type;
   typedef logic [1:0]          sel_type;

   localparam opcode_type OP_INIT     = 4'd0;
   localparam opcode_type OP_ADD_ARC  = 4'd1;
   localparam opcode_type OP_DEL_ARC  = 4'd2;
   localparam opcode_type OP_ADD_EDGE = 4'd3;
   localparam opcode_type OP_DEL_EDGE = 4'd4;
   localparam opcode_type OP_ADD_TERM = 4'd5;
   localparam opcode_type OP_DEL_VERT = 4'd6;
   localparam opcode_type OP_CONTRACT = 4'd7;
   localparam opcode_type OP_QUERY    = 4'd8;

   // Row address selection for a paired read of both matrices
   localparam sel_type SEL_AB = 2'd0;   // out row a, in row b
   localparam sel_type SEL_BA = 2'd1;   // out row b, in row a
   localparam sel_type SEL_AA = 2'd2;   // out row a, in row a
   localparam sel_type SEL_K  = 2'd3;   // sweep row k in both

   localparam count_type ROWS_LIMIT    = COUNT_W'(ROWS);
   localparam count_type VCOUNT_RESET  = COUNT_W'(64);
   localparam count_type RESET_LIMIT   =
      (VCOUNT_RESET < ROWS_LIMIT) ? VCOUNT_RESET : ROWS_LIMIT;
   localparam addr_type  LAST_ROW      = ROW_W'(ROWS - 1);

   typedef struct packed {
      logic    load_item;
      logic    init_graph;
      logic    set_terminal;
      logic    drop_masks;
      logic    rd_pair;
      sel_type sel;
      logic    wr_arc;
      logic    snap;
      logic    wr_sweep;
      logic    acc_query;
      logic    clr_count;
      logic    inc_count;
      logic    load_rsp;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       bad;
      logic       sweep_last;
      logic       rsp_free;
   } status_type;

   // Low n bits set, saturating at the full row
   function automatic row_type low_mask(input count_type n);
      row_type m;
      m = '0;
      for (int i = 0; i < ROW_BITS; i++) begin
         m[i] = (COUNT_W'(i) < n);
      end
      return m;
   endfunction

   function automatic row_type bit_of(input vertex_type v);
      return row_type'(1) << v;
   endfunction

endpackage

/* rtl/dace_ctrl.sv */
// Sequencer for the contraction engine: accepts items and steps the datapath.
// Depends on dace_pkg (command/status structs, opcodes, select codes).
module dace_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  dace_pkg::status_type  status,
   output dace_pkg::cmd_type     cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_ARC1_RD  = 4'd2;
   localparam logic [3:0] S_ARC1_WR  = 4'd3;
   localparam logic [3:0] S_ARC2_RD  = 4'd4;
   localparam logic [3:0] S_ARC2_WR  = 4'd5;
   localparam logic [3:0] S_SNAP_RD  = 4'd6;
   localparam logic [3:0] S_SNAP_CAP = 4'd7;
   localparam logic [3:0] S_SWEEP_RD = 4'd8;
   localparam logic [3:0] S_SWEEP_WR = 4'd9;
   localparam logic [3:0] S_VIEW_RD  = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.clr_count = 1'b1;
            if (status.bad) begin
               state_in = S_VIEW_RD;
            end else begin
               unique case (status.op) inside
                  dace_pkg::OP_INIT: begin
                     cmd.init_graph = 1'b1;
                     state_in       = S_VIEW_RD;
                  end
                  dace_pkg::OP_ADD_TERM: begin
                     cmd.set_terminal = 1'b1;
                     state_in         = S_VIEW_RD;
                  end
                  dace_pkg::OP_ADD_ARC, dace_pkg::OP_DEL_ARC,
                  dace_pkg::OP_ADD_EDGE, dace_pkg::OP_DEL_EDGE: begin
                     state_in = S_ARC1_RD;
                  end
                  dace_pkg::OP_DEL_VERT, dace_pkg::OP_CONTRACT: begin
                     state_in = S_SNAP_RD;
                  end
                  dace_pkg::OP_QUERY: begin
                     state_in = S_SWEEP_RD;
                  end
                  default: begin
                     state_in = S_VIEW_RD;
                  end
               endcase
            end
         end
         S_ARC1_RD: begin
            cmd.rd_pair = 1'b1;
            cmd.sel     = dace_pkg::SEL_AB;
            state_in    = S_ARC1_WR;
         end
         S_ARC1_WR: begin
            cmd.wr_arc = 1'b1;
            if ((status.op == dace_pkg::OP_ADD_EDGE) ||
                (status.op == dace_pkg::OP_DEL_EDGE)) begin
               state_in = S_ARC2_RD;
            end else begin
               state_in = S_VIEW_RD;
            end
         end
         S_ARC2_RD: begin
            cmd.rd_pair = 1'b1;
            cmd.sel     = dace_pkg::SEL_BA;
            state_in    = S_ARC2_WR;
         end
         S_ARC2_WR: begin
            cmd.wr_arc = 1'b1;
            state_in   = S_VIEW_RD;
         end
         S_SNAP_RD: begin
            cmd.rd_pair = 1'b1;
            cmd.sel     = dace_pkg::SEL_AA;
            state_in    = S_SNAP_CAP;
         end
         S_SNAP_CAP: begin
            cmd.snap       = 1'b1;
            cmd.drop_masks = 1'b1;
            state_in       = S_SWEEP_RD;
         end
         S_SWEEP_RD: begin
            cmd.rd_pair = 1'b1;
            cmd.sel     = dace_pkg::SEL_K;
            state_in    = S_SWEEP_WR;
         end
         S_SWEEP_WR: begin
            if (status.op == dace_pkg::OP_QUERY) begin
               cmd.acc_query = 1'b1;
            end else begin
               cmd.wr_sweep = 1'b1;
            end
            cmd.inc_count = 1'b1;
            if (status.sweep_last) begin
               state_in = S_VIEW_RD;
            end else begin
               state_in = S_SWEEP_RD;
            end
         end
         S_VIEW_RD: begin
            cmd.rd_pair = 1'b1;
            cmd.sel     = dace_pkg::SEL_AA;
            state_in    = S_DONE;
         end
         S_DONE: begin
            // hold the read rows until the result register is free
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/dace_datapath.sv */
// Datapath of the contraction engine: adjacency row memories, masks, item and
// result registers. Depends on dace_pkg; driven by commands from dace_ctrl.
module dace_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [6:0]            csr_vertex_count,
   input  logic [3:0]            req_opcode,
   input  logic [5:0]            req_vertex_a,
   input  logic [5:0]            req_vertex_b,
   input  dace_pkg::cmd_type     cmd,
   output dace_pkg::status_type  status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [63:0]           rsp_a_out_row,
   output logic [63:0]           rsp_a_in_row,
   output logic [63:0]           rsp_present_mask,
   output logic [63:0]           rsp_terminal_mask,
   output logic                  rsp_arc_a_to_b,
   output logic                  rsp_a_has_in_b,
   output logic                  rsp_a_is_terminal,
   output logic                  rsp_independent,
   output logic                  rsp_bad_vertex
);

   dace_pkg::count_type  vcount_ff;
   dace_pkg::count_type  lim;

   dace_pkg::opcode_type op_ff;
   dace_pkg::vertex_type a_ff;
   dace_pkg::vertex_type b_ff;
   logic                 bad_ff;
   logic                 req_bad;
   logic                 req_a_ok;
   logic                 req_b_ok;

   dace_pkg::row_type    out_mem [dace_pkg::ROWS];
   dace_pkg::row_type    in_mem  [dace_pkg::ROWS];
   logic [dace_pkg::ROWS-1:0] out_vld_ff;
   logic [dace_pkg::ROWS-1:0] in_vld_ff;

   dace_pkg::addr_type   out_ra;
   dace_pkg::addr_type   in_ra;
   dace_pkg::addr_type   out_ra_ff;
   dace_pkg::addr_type   in_ra_ff;
   dace_pkg::row_type    out_q_ff;
   dace_pkg::row_type    in_q_ff;
   logic                 out_vq_ff;
   logic                 in_vq_ff;
   dace_pkg::row_type    out_row;
   dace_pkg::row_type    in_row;

   dace_pkg::row_type    outs_ff;
   dace_pkg::row_type    ins_ff;
   dace_pkg::row_type    present_ff;
   dace_pkg::row_type    terminal_ff;
   dace_pkg::addr_type   k_ff;
   dace_pkg::vertex_type k6;
   logic                 indep_ff;

   logic                 set_val;
   logic                 is_contract;
   dace_pkg::row_type    out_arc;
   dace_pkg::row_type    in_arc;
   dace_pkg::row_type    out_sw;
   dace_pkg::row_type    in_sw;
   dace_pkg::row_type    k_bit;
   dace_pkg::row_type    v_bit;
   dace_pkg::row_type    out_wd;
   dace_pkg::row_type    in_wd;
   logic                 out_we;
   logic                 in_we;
   logic                 view_ok;

   logic                 rsp_valid_ff;
   dace_pkg::row_type    rsp_out_ff;
   dace_pkg::row_type    rsp_in_ff;
   dace_pkg::row_type    rsp_present_ff;
   dace_pkg::row_type    rsp_terminal_ff;
   logic                 rsp_arc_ff;
   logic                 rsp_has_in_ff;
   logic                 rsp_term_ff;
   logic                 rsp_indep_ff;
   logic                 rsp_bad_ff;

   // Usable vertex limit
   assign lim = (vcount_ff < dace_pkg::ROWS_LIMIT) ? vcount_ff : dace_pkg::ROWS_LIMIT;

   assign req_a_ok = dace_pkg::COUNT_W'(req_vertex_a) < lim;
   assign req_b_ok = dace_pkg::COUNT_W'(req_vertex_b) < lim;

   always_comb begin
      unique case (req_opcode) inside
         dace_pkg::OP_ADD_ARC, dace_pkg::OP_DEL_ARC, dace_pkg::OP_ADD_EDGE,
         dace_pkg::OP_DEL_EDGE, dace_pkg::OP_QUERY: begin
            req_bad = !req_a_ok || !req_b_ok;
         end
         dace_pkg::OP_ADD_TERM, dace_pkg::OP_DEL_VERT, dace_pkg::OP_CONTRACT: begin
            req_bad = !req_a_ok;
         end
         default: begin
            req_bad = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= dace_pkg::VCOUNT_RESET;
      end else if (csr_write_en) begin
         vcount_ff <= csr_vertex_count;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff  <= req_opcode;
         a_ff   <= req_vertex_a;
         b_ff   <= req_vertex_b;
         bad_ff <= req_bad;
      end
   end

   always_comb begin
      unique case (cmd.sel)
         dace_pkg::SEL_AB: begin
            out_ra = a_ff[dace_pkg::ROW_W-1:0];
            in_ra  = b_ff[dace_pkg::ROW_W-1:0];
         end
         dace_pkg::SEL_BA: begin
            out_ra = b_ff[dace_pkg::ROW_W-1:0];
            in_ra  = a_ff[dace_pkg::ROW_W-1:0];
         end
         dace_pkg::SEL_AA: begin
            out_ra = a_ff[dace_pkg::ROW_W-1:0];
            in_ra  = a_ff[dace_pkg::ROW_W-1:0];
         end
         default: begin
            out_ra = k_ff;
            in_ra  = k_ff;
         end
      endcase
   end

   // Row memories: write back to the last read rows, registered read
   always_ff @(posedge clock) begin
      if (out_we) begin
         out_mem[out_ra_ff] <= out_wd;
      end
      if (in_we) begin
         in_mem[in_ra_ff] <= in_wd;
      end
      if (cmd.rd_pair) begin
         out_q_ff <= out_mem[out_ra];
         in_q_ff  <= in_mem[in_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_pair) begin
         out_ra_ff <= out_ra;
         in_ra_ff  <= in_ra;
         out_vq_ff <= out_vld_ff[out_ra];
         in_vq_ff  <= in_vld_ff[in_ra];
      end
   end

   // A row never written since reset or init reads as empty
   always_ff @(posedge clock) begin
      if (reset || cmd.init_graph) begin
         out_vld_ff <= '0;
         in_vld_ff  <= '0;
      end else begin
         if (out_we) begin
            out_vld_ff[out_ra_ff] <= 1'b1;
         end
         if (in_we) begin
            in_vld_ff[in_ra_ff] <= 1'b1;
         end
      end
   end

   assign out_row = out_vq_ff ? out_q_ff : '0;
   assign in_row  = in_vq_ff  ? in_q_ff  : '0;

   // Arc update: out row x gets bit y, in row y gets bit x
   assign set_val = (op_ff == dace_pkg::OP_ADD_ARC) || (op_ff == dace_pkg::OP_ADD_EDGE);
   assign out_arc = set_val
                  ? (out_row | dace_pkg::bit_of(dace_pkg::VERT_W'(in_ra_ff)))
                  : (out_row & ~dace_pkg::bit_of(dace_pkg::VERT_W'(in_ra_ff)));
   assign in_arc  = set_val
                  ? (in_row | dace_pkg::bit_of(dace_pkg::VERT_W'(out_ra_ff)))
                  : (in_row & ~dace_pkg::bit_of(dace_pkg::VERT_W'(out_ra_ff)));

   // Sweep update of row k: add bypass arcs on contract, then drop vertex a
   assign k6          = dace_pkg::VERT_W'(k_ff);
   assign k_bit       = dace_pkg::bit_of(k6);
   assign v_bit       = dace_pkg::bit_of(a_ff);
   assign is_contract = (op_ff == dace_pkg::OP_CONTRACT);
   assign out_sw = (out_row | (is_contract ? (outs_ff & ~k_bit) : '0)) & ~v_bit;
   assign in_sw  = (in_row  | (is_contract ? (ins_ff  & ~k_bit) : '0)) & ~v_bit;

   assign out_we = cmd.wr_arc || (cmd.wr_sweep && ins_ff[k6]);
   assign in_we  = cmd.wr_arc || (cmd.wr_sweep && outs_ff[k6]);
   assign out_wd = cmd.wr_arc ? out_arc : out_sw;
   assign in_wd  = cmd.wr_arc ? in_arc  : in_sw;

   always_ff @(posedge clock) begin
      if (cmd.snap) begin
         outs_ff <= out_row;
         ins_ff  <= in_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= dace_pkg::low_mask(dace_pkg::RESET_LIMIT);
         terminal_ff <= '0;
      end else if (cmd.init_graph) begin
         present_ff  <= dace_pkg::low_mask(lim);
         terminal_ff <= '0;
      end else if (cmd.set_terminal) begin
         terminal_ff <= terminal_ff | v_bit;
      end else if (cmd.drop_masks) begin
         present_ff  <= present_ff & ~v_bit;
         terminal_ff <= terminal_ff & ~v_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_count) begin
         k_ff <= '0;
      end else if (cmd.inc_count) begin
         k_ff <= k_ff + dace_pkg::addr_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         indep_ff <= 1'b1;
      end else if (cmd.acc_query && present_ff[k6] && (|(out_row | in_row))) begin
         indep_ff <= 1'b0;
      end
   end

   assign view_ok = dace_pkg::COUNT_W'(a_ff) < lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_out_ff      <= view_ok ? out_row : '0;
         rsp_in_ff       <= view_ok ? in_row  : '0;
         rsp_present_ff  <= present_ff;
         rsp_terminal_ff <= terminal_ff;
         rsp_arc_ff      <= view_ok && out_row[b_ff];
         rsp_has_in_ff   <= view_ok && in_row[b_ff];
         rsp_term_ff     <= terminal_ff[a_ff];
         rsp_indep_ff    <= indep_ff && (op_ff == dace_pkg::OP_QUERY) && !bad_ff;
         rsp_bad_ff      <= bad_ff;
      end
   end

   assign status.op         = op_ff;
   assign status.bad        = bad_ff;
   assign status.sweep_last = (k_ff == dace_pkg::LAST_ROW);
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_a_out_row     = rsp_out_ff;
   assign rsp_a_in_row      = rsp_in_ff;
   assign rsp_present_mask  = rsp_present_ff;
   assign rsp_terminal_mask = rsp_terminal_ff;
   assign rsp_arc_a_to_b    = rsp_arc_ff;
   assign rsp_a_has_in_b    = rsp_has_in_ff;
   assign rsp_a_is_terminal = rsp_term_ff;
   assign rsp_independent   = rsp_indep_ff;
   assign rsp_bad_vertex    = rsp_bad_ff;

endmodule

/* rtl/digraph_adjacency_contraction_engine_top.sv */
// Top level of the digraph adjacency contraction engine.
// Instantiates dace_ctrl and dace_datapath; depends on dace_pkg.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_opcode, req_vertex_a, req_vertex_b
//   rsp_      out        rsp_valid/rsp_ready  rows of vertex a, both masks, flags
//   csr_      in         csr_write_en         csr_vertex_count (no wait, no read-back)
//
// Every item ends by reading the rows of vertex a into the result register.
// Before that, an arc update reads and writes one row pair and an edge update
// two; remove and contract snapshot the rows of vertex a and then sweep every
// row, as does query. Each swept row is read, then written back or checked.
// Init clears the graph and a terminal item sets its mask bit.
// Synchronous active-high reset resets the row valid bits, masks and control state; no clearing pass.
// A finished result waits in the output register while the next item is taken;
// the engine stalls only at the end of an item if that register is still full.
module digraph_adjacency_contraction_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [6:0]  csr_vertex_count,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [5:0]  req_vertex_a,
   input  logic [5:0]  req_vertex_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_a_out_row,
   output logic [63:0] rsp_a_in_row,
   output logic [63:0] rsp_present_mask,
   output logic [63:0] rsp_terminal_mask,
   output logic        rsp_arc_a_to_b,
   output logic        rsp_a_has_in_b,
   output logic        rsp_a_is_terminal,
   output logic        rsp_independent,
   output logic        rsp_bad_vertex
);

   dace_pkg::cmd_type    cmd;
   dace_pkg::status_type status;

   // Sequencer: one item at a time, commands to the datapath each cycle
   dace_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Matrices, masks, operand latch and result register
   dace_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_vertex_count  (csr_vertex_count),
      .req_opcode        (req_opcode),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_a_out_row     (rsp_a_out_row),
      .rsp_a_in_row      (rsp_a_in_row),
      .rsp_present_mask  (rsp_present_mask),
      .rsp_terminal_mask (rsp_terminal_mask),
      .rsp_arc_a_to_b    (rsp_arc_a_to_b),
      .rsp_a_has_in_b    (rsp_a_has_in_b),
      .rsp_a_is_terminal (rsp_a_is_terminal),
      .rsp_independent   (rsp_independent),
      .rsp_bad_vertex    (rsp_bad_vertex)
   );

   // A result is loaded only into a free output register
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending transfer");

   // Matrix writes happen only while an item is in progress
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_arc || cmd.wr_sweep) |-> !req_ready)
      else $error("matrix write while idle");

   // An accepted item blocks the input until it completes
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second transfer taken while busy");

   // A new result appears only from a load command
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("result valid without load");

endmodule

/* sim/dace_result_checker.sv */
// Response checker for the digraph adjacency contraction engine testbench.
// Tracks the graph from observed request and csr transfers and compares every
// response transfer; depends on dace_pkg.
module dace_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [6:0]  csr_vertex_count,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [3:0]  req_opcode,
   input  logic [5:0]  req_vertex_a,
   input  logic [5:0]  req_vertex_b,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_a_out_row,
   input  logic [63:0] rsp_a_in_row,
   input  logic [63:0] rsp_present_mask,
   input  logic [63:0] rsp_terminal_mask,
   input  logic        rsp_arc_a_to_b,
   input  logic        rsp_a_has_in_b,
   input  logic        rsp_a_is_terminal,
   input  logic        rsp_independent,
   input  logic        rsp_bad_vertex,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      dace_pkg::row_type out_row;
      dace_pkg::row_type in_row;
      dace_pkg::row_type present;
      dace_pkg::row_type terminal;
      logic              arc_ab;
      logic              in_b;
      logic              is_terminal;
      logic              independent;
      logic              bad;
   } vertex_view_type;

   dace_pkg::row_type   out_rows [dace_pkg::ROWS];
   dace_pkg::row_type   in_rows  [dace_pkg::ROWS];
   dace_pkg::row_type   present_set;
   dace_pkg::row_type   terminal_set;
   dace_pkg::count_type vertex_count;
   vertex_view_type     expected_views [$];
   int                  errors   = 0;
   int                  rsp_seen = 0;

   function automatic int usable_limit();
      return (int'(vertex_count) < dace_pkg::ROWS) ? int'(vertex_count) : dace_pkg::ROWS;
   endfunction

   function automatic dace_pkg::row_type one_hot(input int v);
      return dace_pkg::row_type'(1) << v;
   endfunction

   task automatic clear_graph(input int lim);
      for (int k = 0; k < dace_pkg::ROWS; k++) begin
         out_rows[k] = '0;
         in_rows[k]  = '0;
      end
      present_set  = (lim >= dace_pkg::ROW_BITS) ? '1
                                                 : one_hot(lim) - dace_pkg::row_type'(1);
      terminal_set = '0;
   endtask

   task automatic set_arc(input int s, input int t, input logic on);
      if (on) begin
         out_rows[s] |= one_hot(t);
         in_rows[t]  |= one_hot(s);
      end else begin
         out_rows[s] &= ~one_hot(t);
         in_rows[t]  &= ~one_hot(s);
      end
   endtask

   // Unlink v from its neighbours and both masks; its own rows stay, bar a self-loop.
   task automatic drop_vertex(input int v);
      dace_pkg::row_type outs;
      dace_pkg::row_type ins;
      dace_pkg::row_type keep;
      outs = out_rows[v];
      ins  = in_rows[v];
      keep = ~one_hot(v);
      for (int k = 0; k < dace_pkg::ROWS; k++) begin
         if (outs[k]) in_rows[k] &= keep;
      end
      for (int k = 0; k < dace_pkg::ROWS; k++) begin
         if (ins[k]) out_rows[k] &= keep;
      end
      present_set  &= keep;
      terminal_set &= keep;
   endtask

   task automatic contract_vertex(input int v);
      dace_pkg::row_type outs;
      dace_pkg::row_type ins;
      outs = out_rows[v];
      ins  = in_rows[v];
      for (int i = 0; i < dace_pkg::ROWS; i++) begin
         if (ins[i]) begin
            for (int o = 0; o < dace_pkg::ROWS; o++) begin
               if (outs[o] && i != o) set_arc(i, o, 1'b1);
            end
         end
      end
      drop_vertex(v);
   endtask

   function automatic logic graph_independent();
      for (int v = 0; v < dace_pkg::ROWS; v++) begin
         if (present_set[v] && (out_rows[v] != '0 || in_rows[v] != '0)) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic apply_graph_op(input dace_pkg::opcode_type op,
                                 input dace_pkg::vertex_type a,
                                 input dace_pkg::vertex_type b,
                                 output vertex_view_type view);
      int   lim;
      int   ai;
      int   bi;
      logic a_ok;
      logic b_ok;
      logic bad;
      logic indep;
      lim   = usable_limit();
      ai    = int'(a);
      bi    = int'(b);
      a_ok  = ai < lim;
      b_ok  = bi < lim;
      bad   = 1'b0;
      indep = 1'b0;
      case (op)
         dace_pkg::OP_ADD_ARC, dace_pkg::OP_DEL_ARC, dace_pkg::OP_ADD_EDGE,
         dace_pkg::OP_DEL_EDGE, dace_pkg::OP_QUERY:                bad = !a_ok || !b_ok;
         dace_pkg::OP_ADD_TERM, dace_pkg::OP_DEL_VERT,
         dace_pkg::OP_CONTRACT:                                    bad = !a_ok;
         default:                                                  bad = 1'b0;
      endcase
      if (!bad) begin
         case (op)
            dace_pkg::OP_INIT:     clear_graph(lim);
            dace_pkg::OP_ADD_ARC:  set_arc(ai, bi, 1'b1);
            dace_pkg::OP_DEL_ARC:  set_arc(ai, bi, 1'b0);
            dace_pkg::OP_ADD_EDGE: begin
               set_arc(ai, bi, 1'b1);
               set_arc(bi, ai, 1'b1);
            end
            dace_pkg::OP_DEL_EDGE: begin
               set_arc(ai, bi, 1'b0);
               set_arc(bi, ai, 1'b0);
            end
            dace_pkg::OP_ADD_TERM: terminal_set |= one_hot(ai);
            dace_pkg::OP_DEL_VERT: drop_vertex(ai);
            dace_pkg::OP_CONTRACT: contract_vertex(ai);
            dace_pkg::OP_QUERY:    indep = graph_independent();
            default: ;
         endcase
      end
      view.out_row     = a_ok ? out_rows[a] : '0;
      view.in_row      = a_ok ? in_rows[a]  : '0;
      view.present     = present_set;
      view.terminal    = terminal_set;
      view.arc_ab      = view.out_row[b];
      view.in_b        = view.in_row[b];
      view.is_terminal = terminal_set[a];
      view.independent = indep;
      view.bad         = bad;
   endtask

   task automatic report_error(input string msg);
      $display("[%0t] response %0d: %s", $realtime, rsp_seen, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_error($sformatf("%s got %h expected %h", name, got, want));
   endtask

   always @(posedge clock) begin : monitor
      vertex_view_type view;
      vertex_view_type want;
      if (reset) begin
         vertex_count = dace_pkg::VCOUNT_RESET;
         clear_graph(usable_limit());
         expected_views.delete();
      end else begin
         if (csr_write_en) vertex_count = csr_vertex_count;
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_views.size() == 0) begin
               report_error("response transfer with nothing outstanding");
            end else begin
               want = expected_views.pop_front();
               check_field("a_out_row",     rsp_a_out_row,     want.out_row);
               check_field("a_in_row",      rsp_a_in_row,      want.in_row);
               check_field("present_mask",  rsp_present_mask,  want.present);
               check_field("terminal_mask", rsp_terminal_mask, want.terminal);
               check_field("arc_a_to_b",    64'(rsp_arc_a_to_b),    64'(want.arc_ab));
               check_field("a_has_in_b",    64'(rsp_a_has_in_b),    64'(want.in_b));
               check_field("a_is_terminal", 64'(rsp_a_is_terminal), 64'(want.is_terminal));
               check_field("independent",   64'(rsp_independent),   64'(want.independent));
               check_field("bad_vertex",    64'(rsp_bad_vertex),    64'(want.bad));
            end
         end
         if (req_valid && req_ready) begin
            apply_graph_op(dace_pkg::opcode_type'(req_opcode),
                           dace_pkg::vertex_type'(req_vertex_a),
                           dace_pkg::vertex_type'(req_vertex_b), view);
            expected_views.insert(expected_views.size(), view);
         end
      end
      pending    <= expected_views.size();
      fail_count <= errors;
   end

endmodule

/* sim/tb_digraph_adjacency_contraction_engine_top.sv */
// Testbench top for the digraph adjacency contraction engine.
// Drives stimulus and gives the verdict; depends on dace_pkg, dace_result_checker
// and the engine RTL.
module tb_digraph_adjacency_contraction_engine_top;

   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int LONG_HOLD   = 1500;
   localparam int TAIL_CYCLES = 150;
   localparam int NUM_PHASES  = 9;
   localparam int RAND_PHASE  = 7;
   localparam int HOLD_PHASE  = 3;

   // Opcodes the engine ignores
   localparam dace_pkg::opcode_type OP_UNKNOWN_LO = 4'd9;
   localparam dace_pkg::opcode_type OP_UNKNOWN_HI = 4'd15;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 csr_write_en     = 1'b0;
   logic [6:0]           csr_vertex_count = dace_pkg::VCOUNT_RESET;
   logic                 req_valid        = 1'b0;
   dace_pkg::opcode_type req_opcode       = dace_pkg::OP_INIT;
   dace_pkg::vertex_type req_vertex_a     = '0;
   dace_pkg::vertex_type req_vertex_b     = '0;
   logic                 rsp_ready        = 1'b0;

   logic        req_ready;
   logic        rsp_valid;
   logic [63:0] rsp_a_out_row;
   logic [63:0] rsp_a_in_row;
   logic [63:0] rsp_present_mask;
   logic [63:0] rsp_terminal_mask;
   logic        rsp_arc_a_to_b;
   logic        rsp_a_has_in_b;
   logic        rsp_a_is_terminal;
   logic        rsp_independent;
   logic        rsp_bad_vertex;

   int fail_count;
   int pending;
   int burst_left        = 0;
   int cycles            = 0;
   bit long_hold_pending = 1'b0;

   // Vertex counts per random phase: the extremes, some odd sizes, the
   // clamped value above 64 and the empty graph.
   int                  phase_items  [NUM_PHASES] = '{300, 50, 100, 250, 200, 150, 20,
                                                      200, 150};
   dace_pkg::count_type phase_vcount [NUM_PHASES] = '{7'd64, 7'd1, 7'd2, 7'd8, 7'd33,
                                                      7'd127, 7'd0, 7'd64, 7'd63};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   digraph_adjacency_contraction_engine_top uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_vertex_count  (csr_vertex_count),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_a_out_row     (rsp_a_out_row),
      .rsp_a_in_row      (rsp_a_in_row),
      .rsp_present_mask  (rsp_present_mask),
      .rsp_terminal_mask (rsp_terminal_mask),
      .rsp_arc_a_to_b    (rsp_arc_a_to_b),
      .rsp_a_has_in_b    (rsp_a_has_in_b),
      .rsp_a_is_terminal (rsp_a_is_terminal),
      .rsp_independent   (rsp_independent),
      .rsp_bad_vertex    (rsp_bad_vertex)
   );

   dace_result_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_vertex_count  (csr_vertex_count),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_a_out_row     (rsp_a_out_row),
      .rsp_a_in_row      (rsp_a_in_row),
      .rsp_present_mask  (rsp_present_mask),
      .rsp_terminal_mask (rsp_terminal_mask),
      .rsp_arc_a_to_b    (rsp_arc_a_to_b),
      .rsp_a_has_in_b    (rsp_a_has_in_b),
      .rsp_a_is_terminal (rsp_a_is_terminal),
      .rsp_independent   (rsp_independent),
      .rsp_bad_vertex    (rsp_bad_vertex),
      .fail_count        (fail_count),
      .pending           (pending)
   );

   // Offer one request and hold it until the transfer. Requests come in bursts;
   // at the end of a burst drop valid for a random gap, or for none. Valid is left high
   // after the transfer so that back-to-back items need no second assignment.
   task automatic send_item(input dace_pkg::opcode_type op, input dace_pkg::vertex_type a,
                            input dace_pkg::vertex_type b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
   endtask

   // Drop valid and wait until every outstanding response has arrived.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Only call with the engine idle.
   task automatic write_vertex_count(input int count);
      csr_write_en     <= 1'b1;
      csr_vertex_count <= dace_pkg::count_type'(count);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly operands below the limit, often in a dense low corner; some noise
   // from the whole field to hit the bad-vertex path.
   function automatic dace_pkg::vertex_type pick_vertex(input int span);
      if (span == 0 || $urandom_range(0, 99) < 8) begin
         return dace_pkg::vertex_type'($urandom_range(0, 63));
      end
      return dace_pkg::vertex_type'($urandom_range(0, span - 1));
   endfunction

   task automatic send_random_item(input int lim);
      int                   roll;
      int                   span;
      dace_pkg::opcode_type op;
      roll = $urandom_range(0, 99);
      if (roll < 2)       op = dace_pkg::OP_INIT;
      else if (roll < 30) op = dace_pkg::OP_ADD_ARC;
      else if (roll < 38) op = dace_pkg::OP_DEL_ARC;
      else if (roll < 54) op = dace_pkg::OP_ADD_EDGE;
      else if (roll < 60) op = dace_pkg::OP_DEL_EDGE;
      else if (roll < 68) op = dace_pkg::OP_ADD_TERM;
      else if (roll < 75) op = dace_pkg::OP_DEL_VERT;
      else if (roll < 85) op = dace_pkg::OP_CONTRACT;
      else if (roll < 95) op = dace_pkg::OP_QUERY;
      else op = dace_pkg::opcode_type'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
      span = ($urandom_range(0, 1) && lim > 8) ? 8 : lim;
      send_item(op, pick_vertex(span), pick_vertex(span));
   endtask

   // Receiver: segments of always-ready, mostly-ready, mostly-stalled and
   // periodic ready, plus one long hold-off on request from the stimulus.
   initial begin : receiver
      int mode;
      int seg;
      int period;
      int tick;
      forever begin
         mode   = $urandom_range(0, 3);
         seg    = $urandom_range(20, 300);
         period = $urandom_range(2, 8);
         tick   = 0;
         repeat (seg) begin
            @(posedge clock);
            tick++;
            if (long_hold_pending) begin
               long_hold_pending = 1'b0;
               rsp_ready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end else begin
               case (mode)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 9) < 7);
                  2:       rsp_ready <= ($urandom_range(0, 9) < 2);
                  default: rsp_ready <= (tick % period == 0);
               endcase
            end
         end
      end
   end

   // Watchdog: end the run if it never drains.
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("digraph_adjacency_contraction_engine_top test failed");
      $finish;
   end

   initial begin : stimulus
      int vc;
      int lim;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset size of 64 vertices.
      send_item(dace_pkg::OP_QUERY,    6'd0,  6'd63);   // empty graph is independent
      send_item(dace_pkg::OP_ADD_ARC,  6'd0,  6'd63);
      send_item(dace_pkg::OP_ADD_ARC,  6'd63, 6'd63);   // self-loop at the top vertex
      send_item(dace_pkg::OP_ADD_EDGE, 6'd5,  6'd5);    // edge onto itself
      send_item(dace_pkg::OP_DEL_ARC,  6'd0,  6'd63);
      send_item(dace_pkg::OP_ADD_EDGE, 6'd1,  6'd2);
      send_item(dace_pkg::OP_ADD_ARC,  6'd2,  6'd3);
      send_item(dace_pkg::OP_ADD_ARC,  6'd4,  6'd2);
      send_item(dace_pkg::OP_ADD_TERM, 6'd2,  6'd0);
      send_item(dace_pkg::OP_ADD_TERM, 6'd63, 6'd0);
      send_item(dace_pkg::OP_CONTRACT, 6'd2,  6'd1);    // skips the arc back onto 1
      send_item(dace_pkg::OP_DEL_VERT, 6'd63, 6'd63);   // remove with a self-loop
      send_item(dace_pkg::OP_ADD_ARC,  6'd63, 6'd0);    // absent vertex still updated
      send_item(dace_pkg::OP_DEL_EDGE, 6'd4,  6'd1);
      send_item(dace_pkg::OP_CONTRACT, 6'd5,  6'd5);    // contract a self-looped vertex
      send_item(dace_pkg::OP_QUERY,    6'd1,  6'd3);
      send_item(OP_UNKNOWN_LO,         6'd63, 6'd0);
      send_item(OP_UNKNOWN_HI,         6'd0,  6'd63);
      send_item(dace_pkg::OP_INIT,     6'd0,  6'd0);

      // Small graph: operands at and above the limit are flagged.
      wait_for_results();
      write_vertex_count(5);
      send_item(dace_pkg::OP_ADD_ARC,  6'd0,  6'd5);
      send_item(dace_pkg::OP_ADD_TERM, 6'd5,  6'd0);
      send_item(dace_pkg::OP_ADD_EDGE, 6'd3,  6'd4);
      send_item(dace_pkg::OP_CONTRACT, 6'd4,  6'd0);
      send_item(dace_pkg::OP_QUERY,    6'd4,  6'd7);
      send_item(dace_pkg::OP_INIT,     6'd63, 6'd63);

      // Zero vertices: init empties the graph and the query is flagged; init and unknown items are not.
      wait_for_results();
      write_vertex_count(0);
      send_item(dace_pkg::OP_INIT,  6'd0, 6'd0);
      send_item(dace_pkg::OP_QUERY, 6'd0, 6'd0);
      send_item(OP_UNKNOWN_LO,      6'd0, 6'd0);

      // Random phases, one vertex count each, written with the engine drained.
      for (int p = 0; p < NUM_PHASES; p++) begin
         vc = (p == RAND_PHASE) ? $urandom_range(1, 64) : int'(phase_vcount[p]);
         wait_for_results();
         write_vertex_count(vc);
         lim = (vc < dace_pkg::ROWS) ? vc : dace_pkg::ROWS;
         // Stall the receiver for a long stretch while requests keep coming.
         if (p == HOLD_PHASE) long_hold_pending = 1'b1;
         for (int n = 0; n < phase_items[p]; n++) begin
            // In the first phase, pause the sender once mid-phase until the engine drains.
            if (p == 0 && n == phase_items[p] / 2) wait_for_results();
            send_random_item(lim);
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("digraph_adjacency_contraction_engine_top test passed");
      end else begin
         $display("digraph_adjacency_contraction_engine_top test failed");
      end
      $finish;
   end

endmodule
